// ===== hw/rtl/cts_pkg.sv =====
// Shared types, codes, constants and calendar tables for the timestamp converter.
package cts_pkg;

    typedef logic [31:0] t_word;

    // Operation codes of the shared arithmetic unit.
    localparam logic [1:0] OP_MAC   = 2'd0;
    localparam logic [1:0] OP_SUB   = 2'd1;
    localparam logic [1:0] OP_MSUB  = 2'd2;
    localparam logic [1:0] OP_MULHI = 2'd3;

    // Request codes.
    localparam logic REQ_PACK   = 1'b0;
    localparam logic REQ_UNPACK = 1'b1;

    localparam logic [8:0]  DAYS_YEAR    = 9'd365;
    localparam logic [8:0]  DAYS_LEAP    = 9'd366;
    localparam logic [10:0] DAYS_4YEARS  = 11'd1461;
    localparam logic [8:0]  HOURS_DAY    = 9'd24;
    localparam logic [8:0]  SIXTY        = 9'd60;

    // Reciprocals for division by 60 and by 24; the high product word is then
    // shifted right by 5 and by 4 respectively.
    localparam t_word       RECIP_60     = 32'h8888_8889;
    localparam t_word       RECIP_24     = 32'hAAAA_AAAB;

    typedef struct packed {
        logic [1:0] op;
        logic [8:0] k;
    } t_alu_ctrl;

    function automatic logic [8:0] days_before_month(input logic [3:0] whole);
        logic [8:0] d;
        case (whole)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd365;
        endcase
        return d;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] l;
        case (m)
            4'd1:    l = 5'd28;
            4'd3:    l = 5'd30;
            4'd5:    l = 5'd30;
            4'd8:    l = 5'd30;
            4'd10:   l = 5'd30;
            default: l = 5'd31;
        endcase
        return l;
    endfunction

endpackage

// ===== hw/rtl/cts_alu.sv =====
// Shared arithmetic unit: constant multiply-add, multiply-subtract, high product, subtract and compare.
module cts_alu (
    input  cts_pkg::t_alu_ctrl i_ctrl,
    input  cts_pkg::t_word     i_a,
    input  cts_pkg::t_word     i_b,
    output cts_pkg::t_word     o_res,
    output logic               o_ge
);
    import cts_pkg::*;

    t_word       mul_b;
    logic [63:0] prod;
    logic [32:0] diff;

    always_comb begin
        mul_b = (i_ctrl.op == OP_MULHI) ? i_b : 32'(i_ctrl.k);
        prod  = 64'(i_a) * 64'(mul_b);
        diff  = {1'b0, i_a} - {1'b0, i_b};
        o_ge  = ~diff[32];
        case (i_ctrl.op)
            OP_MAC: begin
                o_res = prod[31:0] + i_b;
            end
            OP_MSUB: begin
                o_res = i_b - prod[31:0];
            end
            OP_MULHI: begin
                o_res = prod[63:32];
            end
            default: begin
                o_res = diff[31:0];
            end
        endcase
    end

endmodule

// ===== hw/rtl/calendar_timestamp_converter.sv =====
// Top level of the calendar timestamp converter with its sequencer.
//
// The block converts between seconds since 2000-01-01 00:00:00 and a calendar
// date and time. An input word is taken at a clock edge with i_valid high and
// o_stall low; a result word leaves at an edge with o_valid high and i_stall
// low. Request type 0 packs the date fields into o_stamp_out, request type 1
// unpacks i_stamp_in into the date fields; the unused result fields are zero.
// A pack runs four multiply-add steps, for days, hours, minutes and seconds,
// then loads the result. An unpack divides by 60, 60 and 24 through reciprocal
// multiplication, each by a high-product step and a multiply-subtract step,
// then one step per four-year block, per single year and per month taken off
// the day count, one more to close each of those three loops, and one to load
// the result. Every step uses the one shared arithmetic unit, so the block
// works on one word at a time and holds o_stall high while it is busy; a new
// word can be taken in the cycle after a result is loaded. A finished result
// sits in the output register while the receiver stalls; the next word may be
// accepted meanwhile, but its result waits until the previous one has been
// taken. Reset empties the output register and returns the sequencer to idle.
module calendar_timestamp_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_req_type,
    input  logic [31:0] i_stamp_in,
    input  logic [6:0]  i_year_in,
    input  logic [3:0]  i_month_in,
    input  logic [4:0]  i_day_in,
    input  logic [4:0]  i_hour_in,
    input  logic [5:0]  i_minute_in,
    input  logic [5:0]  i_second_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_stamp_out,
    output logic [6:0]  o_year_out,
    output logic [3:0]  o_month_out,
    output logic [4:0]  o_day_out,
    output logic [4:0]  o_hour_out,
    output logic [5:0]  o_minute_out,
    output logic [5:0]  o_second_out
);
    import cts_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PACK  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_YEAR4 = 3'd3;
    localparam logic [2:0] ST_YEAR1 = 3'd4;
    localparam logic [2:0] ST_MONTH = 3'd5;
    localparam logic [2:0] ST_FIN   = 3'd6;

    localparam logic [1:0] STG_SEC  = 2'd0;
    localparam logic [1:0] STG_MIN  = 2'd1;
    localparam logic [1:0] STG_HOUR = 2'd2;

    logic [2:0]  r_state, n_state;
    logic        r_out_valid, n_out_valid;

    logic        r_req, n_req;
    logic [6:0]  r_year, n_year;
    logic [3:0]  r_month, n_month;
    logic [4:0]  r_day, n_day;
    logic [4:0]  r_hour, n_hour;
    logic [5:0]  r_minute, n_minute;
    logic [5:0]  r_second, n_second;
    t_word       r_acc, n_acc;
    t_word       r_quo, n_quo;
    logic [1:0]  r_cnt, n_cnt;
    logic [1:0]  r_stage, n_stage;
    logic [5:0]  r_sec, n_sec;
    logic [5:0]  r_min, n_min;
    logic [4:0]  r_hr, n_hr;
    logic [15:0] r_days, n_days;
    logic [7:0]  r_yr, n_yr;
    logic [3:0]  r_mon, n_mon;

    logic [31:0] r_stamp_o, n_stamp_o;
    logic [6:0]  r_year_o, n_year_o;
    logic [3:0]  r_month_o, n_month_o;
    logic [4:0]  r_day_o, n_day_o;
    logic [4:0]  r_hour_o, n_hour_o;
    logic [5:0]  r_minute_o, n_minute_o;
    logic [5:0]  r_second_o, n_second_o;

    t_alu_ctrl   alu_ctrl;
    t_word       alu_a;
    t_word       alu_b;
    t_word       alu_res;
    logic        alu_ge;

    logic        accept;
    logic        out_free;
    t_word       quo;
    logic [5:0]  leaps;
    logic [3:0]  whole;
    t_word       offset;
    logic [8:0]  ylen;
    logic [5:0]  mlen;

    cts_alu u_alu (
        .i_ctrl (alu_ctrl),
        .i_a    (alu_a),
        .i_b    (alu_b),
        .o_res  (alu_res),
        .o_ge   (alu_ge)
    );

    assign o_stall  = (r_state != ST_IDLE);
    assign accept   = i_valid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || !i_stall;
    assign quo      = (r_stage == STG_HOUR) ? {4'd0, alu_res[31:4]} : {5'd0, alu_res[31:5]};

    always_comb begin
        leaps = {1'b0, r_year[6:2]} + 6'd1;
        if (r_year[1:0] == 2'd0 && r_month <= 4'd2) begin
            leaps = leaps - 6'd1;
        end
        if (r_month == 4'd0) begin
            whole = 4'd0;
        end else if (r_month > 4'd13) begin
            whole = 4'd12;
        end else begin
            whole = r_month - 4'd1;
        end
        offset = 32'(leaps) + 32'(days_before_month(whole)) + 32'(r_day) - 32'd1;
        ylen = (r_yr[1:0] == 2'd0) ? DAYS_LEAP : DAYS_YEAR;
        mlen = {1'b0, month_len(r_mon)};
        if (r_mon == 4'd1 && r_yr[1:0] == 2'd0) begin
            mlen = mlen + 6'd1;
        end
    end

    always_comb begin
        alu_ctrl.op = OP_SUB;
        alu_ctrl.k  = SIXTY;
        alu_a       = 32'(r_days);
        alu_b       = 32'(DAYS_4YEARS);
        case (r_state)
            ST_PACK: begin
                alu_ctrl.op = OP_MAC;
                alu_a       = r_acc;
                case (r_cnt)
                    2'd0: begin
                        alu_ctrl.k = DAYS_YEAR;
                        alu_a      = 32'(r_year);
                        alu_b      = offset;
                    end
                    2'd1: begin
                        alu_ctrl.k = HOURS_DAY;
                        alu_b      = 32'(r_hour);
                    end
                    2'd2: begin
                        alu_b = 32'(r_minute);
                    end
                    default: begin
                        alu_b = 32'(r_second);
                    end
                endcase
            end
            ST_DIV: begin
                if (r_cnt == 2'd0) begin
                    alu_ctrl.op = OP_MULHI;
                    alu_a       = r_acc;
                    alu_b       = (r_stage == STG_HOUR) ? RECIP_24 : RECIP_60;
                end else begin
                    alu_ctrl.op = OP_MSUB;
                    alu_ctrl.k  = (r_stage == STG_HOUR) ? HOURS_DAY : SIXTY;
                    alu_a       = r_quo;
                    alu_b       = r_acc;
                end
            end
            ST_YEAR1: begin
                alu_b = 32'(ylen);
            end
            ST_MONTH: begin
                alu_b = 32'(mlen);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_req       = r_req;
        n_year      = r_year;
        n_month     = r_month;
        n_day       = r_day;
        n_hour      = r_hour;
        n_minute    = r_minute;
        n_second    = r_second;
        n_acc       = r_acc;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_stage     = r_stage;
        n_sec       = r_sec;
        n_min       = r_min;
        n_hr        = r_hr;
        n_days      = r_days;
        n_yr        = r_yr;
        n_mon       = r_mon;
        n_stamp_o   = r_stamp_o;
        n_year_o    = r_year_o;
        n_month_o   = r_month_o;
        n_day_o     = r_day_o;
        n_hour_o    = r_hour_o;
        n_minute_o  = r_minute_o;
        n_second_o  = r_second_o;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_req    = i_req_type;
                    n_year   = i_year_in;
                    n_month  = i_month_in;
                    n_day    = i_day_in;
                    n_hour   = i_hour_in;
                    n_minute = i_minute_in;
                    n_second = i_second_in;
                    n_acc    = i_stamp_in;
                    n_cnt    = 2'd0;
                    n_stage  = STG_SEC;
                    n_state  = (i_req_type == REQ_PACK) ? ST_PACK : ST_DIV;
                end
            end
            ST_PACK: begin
                n_acc = alu_res;
                n_cnt = r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    n_state = ST_FIN;
                end
            end
            ST_DIV: begin
                if (r_cnt == 2'd0) begin
                    n_quo = quo;
                    n_cnt = 2'd1;
                end else begin
                    n_acc = r_quo;
                    n_cnt = 2'd0;
                    case (r_stage)
                        STG_SEC: begin
                            n_sec   = alu_res[5:0];
                            n_stage = STG_MIN;
                        end
                        STG_MIN: begin
                            n_min   = alu_res[5:0];
                            n_stage = STG_HOUR;
                        end
                        default: begin
                            n_hr    = alu_res[4:0];
                            n_days  = r_quo[15:0];
                            n_yr    = 8'd0;
                            n_state = ST_YEAR4;
                        end
                    endcase
                end
            end
            ST_YEAR4: begin
                if (alu_ge) begin
                    n_days = alu_res[15:0];
                    n_yr   = r_yr + 8'd4;
                end else begin
                    n_state = ST_YEAR1;
                end
            end
            ST_YEAR1: begin
                if (alu_ge) begin
                    n_days = alu_res[15:0];
                    n_yr   = r_yr + 8'd1;
                end else begin
                    n_mon   = 4'd0;
                    n_state = ST_MONTH;
                end
            end
            ST_MONTH: begin
                if (alu_ge && r_mon != 4'd11) begin
                    n_days = alu_res[15:0];
                    n_mon  = r_mon + 4'd1;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                    if (r_req == REQ_PACK) begin
                        n_stamp_o  = r_acc;
                        n_year_o   = 7'd0;
                        n_month_o  = 4'd0;
                        n_day_o    = 5'd0;
                        n_hour_o   = 5'd0;
                        n_minute_o = 6'd0;
                        n_second_o = 6'd0;
                    end else begin
                        n_stamp_o  = 32'd0;
                        n_year_o   = r_yr[6:0];
                        n_month_o  = r_mon + 4'd1;
                        n_day_o    = r_days[4:0] + 5'd1;
                        n_hour_o   = r_hr;
                        n_minute_o = r_min;
                        n_second_o = r_sec;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_year     <= n_year;
        r_month    <= n_month;
        r_day      <= n_day;
        r_hour     <= n_hour;
        r_minute   <= n_minute;
        r_second   <= n_second;
        r_acc      <= n_acc;
        r_quo      <= n_quo;
        r_cnt      <= n_cnt;
        r_stage    <= n_stage;
        r_sec      <= n_sec;
        r_min      <= n_min;
        r_hr       <= n_hr;
        r_days     <= n_days;
        r_yr       <= n_yr;
        r_mon      <= n_mon;
        r_stamp_o  <= n_stamp_o;
        r_year_o   <= n_year_o;
        r_month_o  <= n_month_o;
        r_day_o    <= n_day_o;
        r_hour_o   <= n_hour_o;
        r_minute_o <= n_minute_o;
        r_second_o <= n_second_o;
    end

    assign o_valid      = r_out_valid;
    assign o_stamp_out  = r_stamp_o;
    assign o_year_out   = r_year_o;
    assign o_month_out  = r_month_o;
    assign o_day_out    = r_day_o;
    assign o_hour_out   = r_hour_o;
    assign o_minute_out = r_minute_o;
    assign o_second_out = r_second_o;

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the calendar timestamp converter with a behavioural predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cts_pkg::*;

    typedef struct packed {
        logic        req;
        logic [31:0] stamp;
        logic [6:0]  year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_cal_request;

    typedef struct packed {
        logic [31:0] stamp;
        logic [6:0]  year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_cal_result;

    typedef struct packed {
        t_cal_request rq;
        logic         typed;
        t_cal_result  want;
    } t_dir_row;

    localparam logic [31:0] CUM_DAYS [13] = '{
        32'd0, 32'd31, 32'd59, 32'd90, 32'd120, 32'd151, 32'd181,
        32'd212, 32'd243, 32'd273, 32'd304, 32'd334, 32'd365
    };
    localparam logic [31:0] MONTH_DAYS [12] = '{
        32'd31, 32'd28, 32'd31, 32'd30, 32'd31, 32'd30,
        32'd31, 32'd31, 32'd30, 32'd31, 32'd30, 32'd31
    };
    localparam logic [31:0] LAST_STAMP = 32'd3155759999;
    localparam int N_RANDOM = 1700;
    localparam int HOLD_CYCLES = 600;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_stall;
    logic        i_req_type  = REQ_PACK;
    logic [31:0] i_stamp_in  = '0;
    logic [6:0]  i_year_in   = '0;
    logic [3:0]  i_month_in  = '0;
    logic [4:0]  i_day_in    = '0;
    logic [4:0]  i_hour_in   = '0;
    logic [5:0]  i_minute_in = '0;
    logic [5:0]  i_second_in = '0;
    logic        o_valid;
    logic        i_stall     = 1'b0;
    logic [31:0] o_stamp_out;
    logic [6:0]  o_year_out;
    logic [3:0]  o_month_out;
    logic [4:0]  o_day_out;
    logic [4:0]  o_hour_out;
    logic [5:0]  o_minute_out;
    logic [5:0]  o_second_out;

    t_cal_result due_conversions[$];
    int          n_failures = 0;
    int          n_accepted = 0;
    bit          calm       = 1'b0;

    calendar_timestamp_converter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_req_type   (i_req_type),
        .i_stamp_in   (i_stamp_in),
        .i_year_in    (i_year_in),
        .i_month_in   (i_month_in),
        .i_day_in     (i_day_in),
        .i_hour_in    (i_hour_in),
        .i_minute_in  (i_minute_in),
        .i_second_in  (i_second_in),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_stamp_out  (o_stamp_out),
        .o_year_out   (o_year_out),
        .o_month_out  (o_month_out),
        .o_day_out    (o_day_out),
        .o_hour_out   (o_hour_out),
        .o_minute_out (o_minute_out),
        .o_second_out (o_second_out)
    );

    function automatic t_cal_result calendar_convert(input t_cal_request rq);
        t_cal_result r;
        logic [31:0] y;
        logic [31:0] leaps;
        logic [31:0] whole;
        logic [31:0] days;
        logic [31:0] t;
        logic [31:0] hr;
        logic [31:0] mn;
        logic [31:0] sc;
        logic [31:0] yr;
        logic [31:0] m;
        logic [31:0] mlen;
        r = '0;
        if (rq.req == REQ_PACK) begin
            y = 32'(rq.year);
            leaps = y / 32'd4 + 32'd1;
            if ((y % 32'd4) == 32'd0 && rq.month <= 4'd2)
                leaps = leaps - 32'd1;
            whole = (rq.month == 4'd0) ? 32'd0 : 32'(rq.month) - 32'd1;
            if (whole > 32'd12)
                whole = 32'd12;
            days = y * 32'd365 + leaps + CUM_DAYS[4'(whole)] + 32'(rq.day) - 32'd1;
            r.stamp = ((days * 32'd24 + 32'(rq.hour)) * 32'd60 + 32'(rq.minute)) * 32'd60
                      + 32'(rq.second);
        end else begin
            t = rq.stamp;
            sc = t % 32'd60;
            t = t / 32'd60;
            mn = t % 32'd60;
            t = t / 32'd60;
            hr = t % 32'd24;
            days = t / 32'd24;
            yr = 32'd0;
            while (days >= (((yr % 32'd4) == 32'd0) ? 32'd366 : 32'd365)) begin
                days = days - (((yr % 32'd4) == 32'd0) ? 32'd366 : 32'd365);
                yr = yr + 32'd1;
            end
            m = 32'd0;
            mlen = MONTH_DAYS[0];
            while (m < 32'd12 && days >= mlen) begin
                days = days - mlen;
                m = m + 32'd1;
                if (m < 32'd12)
                    mlen = MONTH_DAYS[4'(m)]
                           + ((m == 32'd1 && (yr % 32'd4) == 32'd0) ? 32'd1 : 32'd0);
            end
            if (m > 32'd11)
                m = 32'd11;
            r.year   = 7'(yr);
            r.month  = 4'(m + 32'd1);
            r.day    = 5'(days + 32'd1);
            r.hour   = 5'(hr);
            r.minute = 6'(mn);
            r.second = 6'(sc);
        end
        return r;
    endfunction

    task automatic log_failure(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        n_failures++;
    endtask

    task automatic offer_word(input t_cal_request rq, input bit typed,
                              input t_cal_result want);
        while (!calm && $urandom_range(99) < 15) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_req_type  <= rq.req;
        i_stamp_in  <= rq.stamp;
        i_year_in   <= rq.year;
        i_month_in  <= rq.month;
        i_day_in    <= rq.day;
        i_hour_in   <= rq.hour;
        i_minute_in <= rq.minute;
        i_second_in <= rq.second;
        do @(posedge i_clk); while (o_stall);
        due_conversions.push_back(typed ? want : calendar_convert(rq));
        n_accepted++;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(6_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        t_dir_row     directed_rows [21];
        t_cal_request rq;
        int unsigned  sel;
        directed_rows = '{
            '{'{REQ_PACK,   32'd0, 7'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0}, 1'b1,
              '{32'd0, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0}},
            '{'{REQ_UNPACK, 32'd0, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0}, 1'b1,
              '{32'd0, 7'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0}},
            '{'{REQ_UNPACK, LAST_STAMP, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0}, 1'b1,
              '{32'd0, 7'd99, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59}},
            '{'{REQ_PACK,   32'd0, 7'd99, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59}, 1'b1,
              '{LAST_STAMP, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0}},
            '{'{REQ_UNPACK, 32'd86399, 7'h7F, 4'hF, 5'h1F, 5'h1F, 6'h3F, 6'h3F}, 1'b1,
              '{32'd0, 7'd0, 4'd1, 5'd1, 5'd23, 6'd59, 6'd59}},
            '{'{REQ_UNPACK, 32'hFFFF_FFFF, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0}, 1'b0, '0},
            '{'{REQ_PACK, 32'hFFFF_FFFF, 7'h7F, 4'hF, 5'h1F, 5'h1F, 6'h3F, 6'h3F}, 1'b0, '0},
            '{'{REQ_PACK,   32'd0, 7'd4, 4'd0, 5'd10, 5'd6, 6'd7, 6'd8}, 1'b0, '0},
            '{'{REQ_PACK,   32'd0, 7'd5, 4'd0, 5'd10, 5'd6, 6'd7, 6'd8}, 1'b0, '0},
            '{'{REQ_PACK,   32'd0, 7'd4, 4'd13, 5'd10, 5'd0, 6'd0, 6'd0}, 1'b0, '0},
            '{'{REQ_PACK,   32'd0, 7'd5, 4'd14, 5'd3, 5'd1, 6'd2, 6'd3}, 1'b0, '0},
            '{'{REQ_PACK,   32'd0, 7'd0, 4'd1, 5'd0, 5'd0, 6'd0, 6'd0}, 1'b0, '0},
            '{'{REQ_PACK,   32'd0, 7'd0, 4'd2, 5'd29, 5'd12, 6'd0, 6'd0}, 1'b0, '0},
            '{'{REQ_PACK,   32'd0, 7'd4, 4'd2, 5'd29, 5'd12, 6'd30, 6'd30}, 1'b0, '0},
            '{'{REQ_PACK,   32'd0, 7'd4, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0}, 1'b0, '0},
            '{'{REQ_PACK,   32'd0, 7'd1, 4'd1, 5'd1, 5'd24, 6'd60, 6'd60}, 1'b0, '0},
            '{'{REQ_PACK,   32'd0, 7'd100, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0}, 1'b0, '0},
            '{'{REQ_UNPACK, 32'd131328000, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0}, 1'b0, '0},
            '{'{REQ_UNPACK, 32'd131327999, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0}, 1'b0, '0},
            '{'{REQ_UNPACK, 32'd31536000, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0}, 1'b0, '0},
            '{'{REQ_UNPACK, 32'd126230400, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0}, 1'b0, '0}
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            offer_word(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].want);

        for (int n = 0; n < N_RANDOM; n++) begin
            calm = (n >= 700 && n < 1000);
            if (n == 1200) begin
                i_valid <= 1'b0;
                while (due_conversions.size() != 0)
                    @(posedge i_clk);
            end
            sel       = $urandom_range(99);
            rq.req    = 1'($urandom);
            rq.stamp  = $urandom;
            rq.year   = 7'($urandom);
            rq.month  = 4'($urandom);
            rq.day    = 5'($urandom);
            rq.hour   = 5'($urandom);
            rq.minute = 6'($urandom);
            rq.second = 6'($urandom);
            if (sel < 40) begin
                rq.req    = REQ_PACK;
                rq.year   = 7'($urandom_range(99));
                rq.month  = 4'($urandom_range(12, 1));
                rq.day    = 5'($urandom_range(31, 1));
                rq.hour   = 5'($urandom_range(23));
                rq.minute = 6'($urandom_range(59));
                rq.second = 6'($urandom_range(59));
            end else if (sel < 80) begin
                rq.req   = REQ_UNPACK;
                rq.stamp = $urandom_range(LAST_STAMP);
            end
            offer_word(rq, 1'b0, '0);
        end
        calm = 1'b0;
        i_valid <= 1'b0;

        while (due_conversions.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (n_failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin : result_checker
        t_cal_result want;
        int          hold_left;
        bit          hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) begin
                if (due_conversions.size() == 0) begin
                    log_failure("output word with no request outstanding");
                end else begin
                    want = due_conversions.pop_front();
                    if (o_stamp_out !== want.stamp)
                        log_failure($sformatf("stamp_out got %0d, expected %0d",
                                              o_stamp_out, want.stamp));
                    if (o_year_out !== want.year)
                        log_failure($sformatf("year_out got %0d, expected %0d",
                                              o_year_out, want.year));
                    if (o_month_out !== want.month)
                        log_failure($sformatf("month_out got %0d, expected %0d",
                                              o_month_out, want.month));
                    if (o_day_out !== want.day)
                        log_failure($sformatf("day_out got %0d, expected %0d",
                                              o_day_out, want.day));
                    if (o_hour_out !== want.hour)
                        log_failure($sformatf("hour_out got %0d, expected %0d",
                                              o_hour_out, want.hour));
                    if (o_minute_out !== want.minute)
                        log_failure($sformatf("minute_out got %0d, expected %0d",
                                              o_minute_out, want.minute));
                    if (o_second_out !== want.second)
                        log_failure($sformatf("second_out got %0d, expected %0d",
                                              o_second_out, want.second));
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (!hold_done && n_accepted >= 400) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                i_stall <= 1'b1;
            end else begin
                i_stall <= !calm && ($urandom_range(99) < 15);
            end
        end
    end

endmodule
